[src/ilp_pkg.sv]
// ----------------------------------------------------------------------------
// Integer literal parser package
// Codes, character constants and types shared by the parser RTL.
// ----------------------------------------------------------------------------
package ilp_pkg;

   typedef enum logic [1:0] {
      RADIX_DEC = 2'd0,
      RADIX_HEX = 2'd1,
      RADIX_OCT = 2'd2,
      RADIX_BIN = 2'd3
   } radix_type;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_DIGIT    = 2'd1,
      ERR_OVERFLOW = 2'd2
   } err_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_BAD_DIGIT   = 3'd1,
      ST_OVERFLOW    = 3'd2,
      ST_NO_DIGITS   = 3'd3,
      ST_TUPLE_BASE  = 3'd4,
      ST_TUPLE_ZERO  = 3'd5,
      ST_TUPLE_LARGE = 3'd6
   } status_type;

   localparam int unsigned VALUE_W = 63;
   localparam int unsigned PROD_W  = VALUE_W + 4;

   localparam logic [7:0] CHAR_ZERO       = 8'h30;
   localparam logic [7:0] CHAR_NINE       = 8'h39;
   localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F    = 8'h66;
   localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F    = 8'h46;
   localparam logic [7:0] CHAR_X          = 8'h78;
   localparam logic [7:0] CHAR_O          = 8'h6F;
   localparam logic [7:0] CHAR_B          = 8'h62;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

endpackage

[src/integer_literal_parser_top.sv]
// ----------------------------------------------------------------------------
// Integer literal parser
// Parses one integer literal, one character per request, with radix prefix.
// ----------------------------------------------------------------------------
// The block takes one character request per clock cycle, back to back, while not
// stalled. Each accepted request is held in an input register, then a single pass
// of logic (digit decode, multiply by the base as shifts and adds, one 67-bit add
// and overflow test) updates the parse state. A request with last set loads the
// result register when processed, and that register drives the response. The
// response register decouples the two channels; the block stalls requests only
// while a response is held and the consumer stalls. The user must write the
// tuple_mode bit through csr_write and csr_wdata while idle; the block does not enforce it.
module integer_literal_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic        csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   input  logic        req_has_char,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [62:0] rsp_value,
   output logic [2:0]  rsp_status,
   output logic        rsp_radix_prefix,
   output logic        rsp_zero_padded
);

   logic                 tuple_mode_ff;
   logic                 in_valid_ff;
   logic [7:0]           char_ff;
   logic                 has_char_ff;
   logic                 last_ff;

   logic [62:0]          accum_ff;
   ilp_pkg::radix_type   radix_ff;
   logic                 prefix_seen_ff;
   logic [1:0]           char_pos_ff;
   logic                 first_zero_ff;
   logic                 any_digit_ff;
   logic [1:0]           zero_count_ff;
   ilp_pkg::err_type     err_ff;

   logic [62:0]          accum_in;
   ilp_pkg::radix_type   radix_in;
   logic                 prefix_seen_in;
   logic [1:0]           char_pos_in;
   logic                 first_zero_in;
   logic                 any_digit_in;
   logic [1:0]           zero_count_in;
   ilp_pkg::err_type     err_in;

   logic                 rsp_valid_ff;
   logic [62:0]          value_ff;
   ilp_pkg::status_type  status_ff;
   logic                 radix_prefix_ff;
   logic                 zero_padded_ff;

   logic [62:0]          value_in;
   ilp_pkg::status_type  status_in;
   logic                 radix_prefix_in;
   logic                 zero_padded_in;

   logic                 advance;
   logic                 process;
   logic                 accept;

   logic                 is_dec;
   logic                 is_hex_letter;
   logic                 digit_ok;
   logic [3:0]           digit;
   logic                 is_prefix;
   logic [ilp_pkg::PROD_W-1:0] product;
   logic [ilp_pkg::PROD_W-1:0] sum;
   logic                 value_is_zero;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign process   = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   // Character decode and accumulate.
   always_comb begin
      is_dec = (char_ff >= ilp_pkg::CHAR_ZERO) && (char_ff <= ilp_pkg::CHAR_NINE);
      is_hex_letter = ((char_ff >= ilp_pkg::CHAR_LOWER_A) &&
                       (char_ff <= ilp_pkg::CHAR_LOWER_F)) ||
                      ((char_ff >= ilp_pkg::CHAR_UPPER_A) &&
                       (char_ff <= ilp_pkg::CHAR_UPPER_F));
      digit = is_dec ? char_ff[3:0] : (char_ff[3:0] + 4'd9);
      product = '0;
      digit_ok = 1'b0;
      case (radix_ff)
         ilp_pkg::RADIX_HEX: begin
            digit_ok = is_dec || is_hex_letter;
            product  = {accum_ff, 4'b0000};
         end
         ilp_pkg::RADIX_OCT: begin
            digit_ok = is_dec && (char_ff[3:0] < 4'd8);
            product  = {1'b0, accum_ff, 3'b000};
         end
         ilp_pkg::RADIX_BIN: begin
            digit_ok = is_dec && (char_ff[3:0] < 4'd2);
            product  = {3'b000, accum_ff, 1'b0};
         end
         default: begin
            digit_ok = is_dec;
            product  = {1'b0, accum_ff, 3'b000} + {3'b000, accum_ff, 1'b0};
         end
      endcase
      sum = product + {{(ilp_pkg::PROD_W-4){1'b0}}, digit};
      is_prefix = (char_pos_ff == 2'd1) && first_zero_ff && !prefix_seen_ff &&
                  ((char_ff == ilp_pkg::CHAR_X) || (char_ff == ilp_pkg::CHAR_O) ||
                   (char_ff == ilp_pkg::CHAR_B));

      accum_in       = accum_ff;
      radix_in       = radix_ff;
      prefix_seen_in = prefix_seen_ff;
      char_pos_in    = char_pos_ff;
      first_zero_in  = first_zero_ff;
      any_digit_in   = any_digit_ff;
      zero_count_in  = zero_count_ff;
      err_in         = err_ff;

      if (has_char_ff) begin
         if (err_ff == ilp_pkg::ERR_NONE) begin
            if (is_prefix) begin
               if (char_ff == ilp_pkg::CHAR_X) begin
                  radix_in = ilp_pkg::RADIX_HEX;
               end else if (char_ff == ilp_pkg::CHAR_O) begin
                  radix_in = ilp_pkg::RADIX_OCT;
               end else begin
                  radix_in = ilp_pkg::RADIX_BIN;
               end
               prefix_seen_in = 1'b1;
               accum_in       = '0;
               any_digit_in   = 1'b0;
               zero_count_in  = 2'd0;
            end else if (char_ff != ilp_pkg::CHAR_UNDERSCORE) begin
               if (!digit_ok) begin
                  err_in = ilp_pkg::ERR_DIGIT;
               end else begin
                  any_digit_in = 1'b1;
                  if ((accum_ff == '0) && (digit == 4'd0) && (zero_count_ff != 2'd2)) begin
                     zero_count_in = zero_count_ff + 2'd1;
                  end
                  if (sum[ilp_pkg::PROD_W-1:ilp_pkg::VALUE_W] != '0) begin
                     err_in = ilp_pkg::ERR_OVERFLOW;
                  end else begin
                     accum_in = sum[ilp_pkg::VALUE_W-1:0];
                  end
               end
            end
         end
         if (char_pos_ff == 2'd0) begin
            first_zero_in = (char_ff == ilp_pkg::CHAR_ZERO);
         end
         if (char_pos_ff != 2'd2) begin
            char_pos_in = char_pos_ff + 2'd1;
         end
      end
   end

   // Result formation from the updated state.
   always_comb begin
      value_is_zero    = (accum_in == '0);
      value_in         = '0;
      radix_prefix_in  = 1'b0;
      zero_padded_in   = 1'b0;
      status_in        = ilp_pkg::ST_OK;
      case (err_in)
         ilp_pkg::ERR_DIGIT: begin
            status_in = ilp_pkg::ST_BAD_DIGIT;
         end
         ilp_pkg::ERR_OVERFLOW: begin
            status_in = ilp_pkg::ST_OVERFLOW;
         end
         default: begin
            if (!any_digit_in) begin
               status_in = ilp_pkg::ST_NO_DIGITS;
            end else begin
               radix_prefix_in = prefix_seen_in;
               zero_padded_in  = value_is_zero ? (zero_count_in == 2'd2)
                                               : (zero_count_in != 2'd0);
               if (tuple_mode_ff) begin
                  if (radix_prefix_in) begin
                     status_in = ilp_pkg::ST_TUPLE_BASE;
                  end else if (zero_padded_in) begin
                     status_in = ilp_pkg::ST_TUPLE_ZERO;
                  end else if (accum_in[62:32] != '0) begin
                     status_in = ilp_pkg::ST_TUPLE_LARGE;
                  end
               end
               if (status_in == ilp_pkg::ST_OK) begin
                  value_in = accum_in;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tuple_mode_ff <= 1'b0;
      end else if (csr_write) begin
         tuple_mode_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (accept) begin
         in_valid_ff <= 1'b1;
      end else if (process) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         char_ff     <= req_char_code;
         has_char_ff <= req_has_char;
         last_ff     <= req_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff       <= '0;
         radix_ff       <= ilp_pkg::RADIX_DEC;
         prefix_seen_ff <= 1'b0;
         char_pos_ff    <= 2'd0;
         first_zero_ff  <= 1'b0;
         any_digit_ff   <= 1'b0;
         zero_count_ff  <= 2'd0;
         err_ff         <= ilp_pkg::ERR_NONE;
      end else if (process) begin
         if (last_ff) begin
            accum_ff       <= '0;
            radix_ff       <= ilp_pkg::RADIX_DEC;
            prefix_seen_ff <= 1'b0;
            char_pos_ff    <= 2'd0;
            first_zero_ff  <= 1'b0;
            any_digit_ff   <= 1'b0;
            zero_count_ff  <= 2'd0;
            err_ff         <= ilp_pkg::ERR_NONE;
         end else begin
            accum_ff       <= accum_in;
            radix_ff       <= radix_in;
            prefix_seen_ff <= prefix_seen_in;
            char_pos_ff    <= char_pos_in;
            first_zero_ff  <= first_zero_in;
            any_digit_ff   <= any_digit_in;
            zero_count_ff  <= zero_count_in;
            err_ff         <= err_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (process && last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (process && last_ff) begin
         value_ff        <= value_in;
         status_ff       <= status_in;
         radix_prefix_ff <= radix_prefix_in;
         zero_padded_ff  <= zero_padded_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_value        = value_ff;
   assign rsp_status       = status_ff;
   assign rsp_radix_prefix = radix_prefix_ff;
   assign rsp_zero_padded  = zero_padded_ff;

endmodule
